FILE: rtl/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg: shared types and constants
// Queue geometry, fixed-point limits, request codes and the slot record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned DIV_NUM_W   = 64;  // v*v - vf*vf
  localparam int unsigned DIV_DEN_W   = 34;  // 2a, signed
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_NUM_W);

  localparam logic signed [31:0] Q_ONE         = 32'sd65536;
  localparam logic signed [31:0] NEG_VEL_LIMIT = -32'sd66;

  localparam logic [31:0] TICK_PERIOD_RST = 32'd4294967;
  localparam logic [15:0] START_DELAY_RST = 16'd500;

  // request codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  // register indexes
  localparam logic CFG_TICK_PERIOD = 1'b0;
  localparam logic CFG_START_DELAY = 1'b1;

  // add status
  localparam logic [2:0] ADD_NONE         = 3'd0;
  localparam logic [2:0] ADD_OK           = 3'd1;
  localparam logic [2:0] ADD_FULL         = 3'd2;
  localparam logic [2:0] ADD_BAD_DIST     = 3'd3;
  localparam logic [2:0] ADD_OUT_OF_ORDER = 3'd4;

  // queue phase
  localparam logic [1:0] PH_EMPTY   = 2'd0;
  localparam logic [1:0] PH_AWAIT   = 2'd1;
  localparam logic [1:0] PH_LOAD    = 2'd2;
  localparam logic [1:0] PH_RUNNING = 2'd3;

  typedef struct packed {
    logic [31:0]        number;
    logic signed [31:0] distance;
    logic signed [31:0] start_vel;
    logic signed [31:0] accel;
    logic signed [31:0] max_vel;
    logic signed [31:0] end_vel;
    logic signed [17:0] unit;
  } slot_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msq_div.sv
// ----------------------------------------------------------------------------
// msq_div: signed radix-2 divider
// Restoring division, one quotient bit per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_div (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       start_i,
  input  wire logic signed [msq_pkg::DIV_NUM_W-1:0] num_i,
  input  wire logic signed [msq_pkg::DIV_DEN_W-1:0] den_i,
  output logic signed [msq_pkg::DIV_NUM_W-1:0]      quo_o,
  output msq_pkg::div_stat_t                        stat_o
);

  logic                               busy_q, done_q, neg_q;
  logic [msq_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [msq_pkg::DIV_NUM_W-1:0]      sh_q;
  logic [msq_pkg::DIV_DEN_W-2:0]      rem_q, den_q;
  logic [msq_pkg::DIV_DEN_W-1:0]      trial;
  logic                               ge;

  assign trial = {rem_q, sh_q[msq_pkg::DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      sh_q   <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sh_q   <= num_i[msq_pkg::DIV_NUM_W-1] ? msq_pkg::DIV_NUM_W'(-num_i)
                                               : msq_pkg::DIV_NUM_W'(num_i);
        den_q  <= den_i[msq_pkg::DIV_DEN_W-1] ? (msq_pkg::DIV_DEN_W-1)'(-den_i)
                                               : (msq_pkg::DIV_DEN_W-1)'(den_i);
        neg_q  <= num_i[msq_pkg::DIV_NUM_W-1] ^ den_i[msq_pkg::DIV_DEN_W-1];
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? (msq_pkg::DIV_DEN_W-1)'(trial - {1'b0, den_q})
                    : trial[msq_pkg::DIV_DEN_W-2:0];
        sh_q  <= {sh_q[msq_pkg::DIV_NUM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == msq_pkg::DIV_CNT_W'(msq_pkg::DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quo_o       = neg_q ? -$signed(sh_q) : $signed(sh_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/motion_segment_queue_stepper_core.sv
// An add request or an idle tick goes from S_IDLE straight to S_FIN.
// A running tick steps through the sequencer states, using the radix-2 divider
// for the stopping distance and the shared 33x33 multiplier for the rest.
// With zero acceleration the divide is skipped.
// One request at a time; a finished result waits in the output register.
// Reset is asynchronous, active low; the slot store itself is not cleared.
// ----------------------------------------------------------------------------
// motion_segment_queue_stepper_core: segment queue and trapezoidal stepper
// Ring of motion segments plus a one-axis Q16.16 integrator that issues steps.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_segment_queue_stepper_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  // request channel
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               cmd_i,
  input  wire [31:0]        seg_number_i,
  input  wire signed [31:0] seg_distance_i,
  input  wire signed [31:0] seg_start_vel_i,
  input  wire signed [31:0] seg_accel_i,
  input  wire signed [31:0] seg_max_vel_i,
  input  wire signed [31:0] seg_end_vel_i,
  input  wire signed [17:0] axis_unit_i,
  // result channel
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              step_pulse_o,
  output logic              step_forward_o,
  output logic              segment_done_o,
  output logic [31:0]       done_number_o,
  output logic [2:0]        add_status_o,
  output logic [1:0]        run_state_o,
  output logic signed [31:0] axis_velocity_o,
  // configuration write channel
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire               cfg_index_i,
  input  wire [31:0]        cfg_data_i
);

  // sequencer states; each multiply is issued in one state and used in the next
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_VV   = 4'd1;   // issue v*v
  localparam logic [3:0] S_FF   = 4'd2;   // keep v*v, issue vf*vf
  localparam logic [3:0] S_DIVS = 4'd3;   // launch divide by 2a
  localparam logic [3:0] S_DIVW = 4'd4;   // wait for quotient, pick accel sign
  localparam logic [3:0] S_AD   = 4'd5;   // issue a_used*dt
  localparam logic [3:0] S_V    = 4'd6;   // new velocity, clamp
  localparam logic [3:0] S_P    = 4'd7;   // issue v*dt
  localparam logic [3:0] S_PA   = 4'd8;   // progress, issue v*unit
  localparam logic [3:0] S_AV   = 4'd9;   // axis velocity
  localparam logic [3:0] S_AX   = 4'd10;  // issue axis_vel*dt
  localparam logic [3:0] S_STEP = 4'd11;  // position, step, completion
  localparam logic [3:0] S_FIN  = 4'd12;  // hand result to output register

  logic [3:0]                    state_q;
  logic [1:0]                    phase_q;
  logic [msq_pkg::SLOT_W-1:0]    run_slot_q, write_slot_q;
  logic [msq_pkg::SLOT_W-1:0]    run_next, write_next;
  logic [msq_pkg::QUEUE_DEPTH-1:0] ready_q;
  logic [15:0]                   delay_q, start_delay_q;
  logic [31:0]                   tick_period_q, exp_num_q;
  logic signed [31:0]            vel_q, prog_q, srem_q, axv_q;
  logic [47:0]                   pos_q;

  // slot store: one write port (add), one registered read port (run slot)
  msq_pkg::slot_t                mem [msq_pkg::QUEUE_DEPTH];
  msq_pkg::slot_t                rd_q;

  // shared multiplier
  logic signed [32:0]            mul_a, mul_b;
  logic signed [65:0]            p_q, vv_q;
  logic signed [32:0]            used_q;

  // per-request result
  logic                          res_step_q, res_fwd_q, res_done_q;
  logic [31:0]                   res_num_q;
  logic [2:0]                    res_status_q;

  // output register
  logic                          out_valid_q;
  logic                          out_load;

  // divider
  logic signed [msq_pkg::DIV_NUM_W-1:0] div_quo;
  msq_pkg::div_stat_t                   div_stat;
  logic                                 div_start;

  logic                          accept;
  msq_pkg::slot_t                add_slot;
  logic                          add_take;

  logic signed [31:0]            v_sat, v_clamp, prog_new, axv_new, delta;
  logic signed [31:0]            sr_sum, prog_carry;
  logic signed [33:0]            dist_diff;
  logic [33:0]                   dist_abs;
  logic                          use_neg;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign run_next   = (run_slot_q == msq_pkg::SLOT_W'(msq_pkg::QUEUE_DEPTH - 1))
                      ? '0 : run_slot_q + 1'b1;
  assign write_next = (write_slot_q == msq_pkg::SLOT_W'(msq_pkg::QUEUE_DEPTH - 1))
                      ? '0 : write_slot_q + 1'b1;

  // an add is stored only if its slot is free and its distance positive
  assign add_take = accept && (cmd_i == msq_pkg::CMD_ADD) && !ready_q[write_slot_q]
                    && (seg_distance_i > 32'sd0);

  always_comb begin
    add_slot.number    = seg_number_i;
    add_slot.distance  = seg_distance_i;
    add_slot.start_vel = seg_start_vel_i;
    add_slot.accel     = seg_accel_i;
    add_slot.max_vel   = seg_max_vel_i;
    add_slot.end_vel   = seg_end_vel_i;
    add_slot.unit      = axis_unit_i;
  end

  always_ff @(posedge clk_i) begin
    if (add_take) begin
      mem[write_slot_q] <= add_slot;
    end
    rd_q <= mem[run_slot_q];
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_VV: begin
        mul_a = 33'(vel_q);
        mul_b = 33'(vel_q);
      end
      S_FF: begin
        mul_a = 33'(rd_q.end_vel);
        mul_b = 33'(rd_q.end_vel);
      end
      S_AD: begin
        mul_a = used_q;
        mul_b = $signed({1'b0, tick_period_q});
      end
      S_P: begin
        mul_a = 33'(vel_q);
        mul_b = $signed({1'b0, tick_period_q});
      end
      S_PA: begin
        mul_a = 33'(vel_q);
        mul_b = 33'(rd_q.unit);
      end
      S_AX: begin
        mul_a = 33'(axv_q);
        mul_b = $signed({1'b0, tick_period_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // stopping distance (v*v - vf*vf) / (2a)
  assign div_start = (state_q == S_DIVS);

  msq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (msq_pkg::DIV_NUM_W'(vv_q - p_q)),
    .den_i   ({rd_q.accel[31], rd_q.accel, 1'b0}),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // datapath values taken from the multiplier register in each state
  always_comb begin
    v_sat      = msq_pkg::sat32(66'(vel_q) + (p_q >>> 32));
    v_clamp    = (v_sat > rd_q.max_vel) ? rd_q.max_vel : v_sat;
    prog_new   = msq_pkg::sat32(66'(prog_q) + (p_q >>> 32));
    axv_new    = msq_pkg::sat32(p_q >>> 16);
    delta      = 32'(p_q >>> 32);
    sr_sum     = msq_pkg::sat32(66'(srem_q) + 66'(delta));
    prog_carry = msq_pkg::sat32(66'(prog_q) - 66'(rd_q.distance));
    dist_diff  = 34'(rd_q.distance) - 34'(prog_q);
    dist_abs   = dist_diff[33] ? 34'(-dist_diff) : 34'(dist_diff);
    use_neg    = div_quo > $signed({30'd0, dist_abs});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= msq_pkg::PH_EMPTY;
      run_slot_q    <= '0;
      write_slot_q  <= '0;
      ready_q       <= '0;
      delay_q       <= '0;
      start_delay_q <= msq_pkg::START_DELAY_RST;
      tick_period_q <= msq_pkg::TICK_PERIOD_RST;
      exp_num_q     <= '0;
      vel_q         <= '0;
      prog_q        <= '0;
      srem_q        <= '0;
      axv_q         <= '0;
      pos_q         <= '0;
      vv_q          <= '0;
      used_q        <= '0;
      res_step_q    <= 1'b0;
      res_fwd_q     <= 1'b0;
      res_done_q    <= 1'b0;
      res_num_q     <= '0;
      res_status_q  <= msq_pkg::ADD_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          msq_pkg::CFG_TICK_PERIOD: tick_period_q <= cfg_data_i;
          msq_pkg::CFG_START_DELAY: start_delay_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_step_q   <= 1'b0;
            res_fwd_q    <= 1'b0;
            res_done_q   <= 1'b0;
            res_num_q    <= '0;
            res_status_q <= msq_pkg::ADD_NONE;
            state_q      <= S_FIN;
            if (cmd_i == msq_pkg::CMD_ADD) begin
              // full is checked before distance
              if (ready_q[write_slot_q]) begin
                res_status_q <= msq_pkg::ADD_FULL;
              end else if (!(seg_distance_i > 32'sd0)) begin
                res_status_q <= msq_pkg::ADD_BAD_DIST;
              end else begin
                ready_q[write_slot_q] <= 1'b1;
                write_slot_q          <= write_next;
                if (seg_number_i == exp_num_q) begin
                  res_status_q <= msq_pkg::ADD_OK;
                  exp_num_q    <= exp_num_q + 32'd1;
                end else begin
                  res_status_q <= msq_pkg::ADD_OUT_OF_ORDER;
                end
              end
            end else if (ready_q[run_slot_q]) begin
              unique case (phase_q)
                msq_pkg::PH_EMPTY: begin
                  prog_q  <= '0;
                  delay_q <= start_delay_q;
                  phase_q <= msq_pkg::PH_AWAIT;
                end
                msq_pkg::PH_AWAIT: begin
                  if (delay_q == '0) begin
                    phase_q <= msq_pkg::PH_LOAD;
                  end else begin
                    delay_q <= delay_q - 16'd1;
                  end
                end
                default: begin
                  // loading or running: integrate
                  if (phase_q == msq_pkg::PH_LOAD) begin
                    vel_q   <= rd_q.start_vel;
                    phase_q <= msq_pkg::PH_RUNNING;
                  end
                  if (rd_q.accel == 32'sd0) begin
                    used_q  <= '0;
                    state_q <= S_AD;
                  end else begin
                    state_q <= S_VV;
                  end
                end
              endcase
            end
          end
        end
        S_VV: state_q <= S_FF;
        S_FF: begin
          vv_q    <= p_q;
          state_q <= S_DIVS;
        end
        S_DIVS: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_stat.done) begin
            used_q  <= use_neg ? -33'(rd_q.accel) : 33'(rd_q.accel);
            state_q <= S_AD;
          end
        end
        S_AD: state_q <= S_V;
        S_V: begin
          if (v_sat <= msq_pkg::NEG_VEL_LIMIT) begin
            // reversing: stop and skip the rest of the tick
            vel_q   <= '0;
            state_q <= S_FIN;
          end else begin
            vel_q   <= v_clamp;
            state_q <= S_P;
          end
        end
        S_P: state_q <= S_PA;
        S_PA: begin
          prog_q  <= prog_new;
          state_q <= S_AV;
        end
        S_AV: begin
          axv_q   <= axv_new;
          state_q <= S_AX;
        end
        S_AX: state_q <= S_STEP;
        S_STEP: begin
          pos_q <= pos_q + 48'(delta);
          if (sr_sum > msq_pkg::Q_ONE) begin
            res_step_q <= 1'b1;
            res_fwd_q  <= 1'b1;
            srem_q     <= sr_sum - msq_pkg::Q_ONE;
          end else if (sr_sum < -msq_pkg::Q_ONE) begin
            res_step_q <= 1'b1;
            srem_q     <= sr_sum + msq_pkg::Q_ONE;
          end else begin
            srem_q <= sr_sum;
          end
          // segment complete: carry excess progress into the next one
          if (prog_q >= rd_q.distance) begin
            ready_q[run_slot_q] <= 1'b0;
            res_done_q          <= 1'b1;
            res_num_q           <= rd_q.number;
            prog_q              <= prog_carry;
            run_slot_q          <= run_next;
            if (ready_q[run_next]) begin
              phase_q <= msq_pkg::PH_LOAD;
            end else begin
              phase_q <= msq_pkg::PH_EMPTY;
              axv_q   <= '0;
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      step_pulse_o    <= res_step_q;
      step_forward_o  <= res_fwd_q;
      segment_done_o  <= res_done_q;
      done_number_o   <= res_num_q;
      add_status_o    <= res_status_q;
      run_state_o     <= phase_q;
      axis_velocity_o <= axv_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/msq_checker.sv
// ----------------------------------------------------------------------------
// msq_checker: port-level checks
// Result handshake and consistency of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire        step_pulse_o,
  input wire        step_forward_o,
  input wire        segment_done_o,
  input wire [31:0] done_number_o,
  input wire [2:0]  add_status_o,
  input wire [1:0]  run_state_o,
  input wire [31:0] axis_velocity_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(done_number_o) && $stable(axis_velocity_o)
      && $stable(run_state_o) && $stable(add_status_o))
    else $error("stalled result changed");

  a_fwd_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_forward_o |-> step_pulse_o)
    else $error("direction without step");

  a_done_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (segment_done_o || step_pulse_o) |-> add_status_o == msq_pkg::ADD_NONE)
    else $error("motion reported on an add request");

  a_number_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !segment_done_o |-> done_number_o == 32'd0)
    else $error("done number without completion");

endmodule

bind motion_segment_queue_stepper_core msq_checker u_msq_checker (.*);

`default_nettype wire
